// ===== rtl/core/envelope_frame_parser_unit_defines.svh =====
// ----------------------------------------------------------------------------
// envelope frame parser assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_FRAME_PARSER_UNIT_DEFINES_SVH
`define ENVELOPE_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define EFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("efp same-cycle check failed");

// next-cycle implication
`define EFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("efp next-cycle check failed");

`endif

// ===== rtl/core/efp_pkg.sv =====
// ----------------------------------------------------------------------------
// efp_pkg
// section tags, status codes, register indexes and header tables
// ----------------------------------------------------------------------------
package efp_pkg;

    typedef logic [4:0] t_sec;
    typedef logic [2:0] t_status;
    typedef logic [7:0] t_reg_idx;

    localparam t_sec SEC_MAGIC    = 5'd0;
    localparam t_sec SEC_VERSION  = 5'd1;
    localparam t_sec SEC_KIND     = 5'd2;
    localparam t_sec SEC_FLAGS    = 5'd3;
    localparam t_sec SEC_SEQ      = 5'd4;
    localparam t_sec SEC_TIME     = 5'd5;
    localparam t_sec SEC_HDRSEQ   = 5'd6;
    localparam t_sec SEC_STR_LAST = 5'd13;
    localparam t_sec SEC_LONG_STR = 5'd10;
    localparam t_sec SEC_LATCH    = 5'd14;
    localparam t_sec SEC_PAYLEN   = 5'd15;
    localparam t_sec SEC_PAYLOAD  = 5'd16;

    localparam t_status ST_OK         = 3'd0;
    localparam t_status ST_MAGIC      = 3'd1;
    localparam t_status ST_SHORT_HDR  = 3'd2;
    localparam t_status ST_VERSION    = 3'd3;
    localparam t_status ST_KIND       = 3'd4;
    localparam t_status ST_SHORT_META = 3'd5;
    localparam t_status ST_LATCH      = 3'd6;
    localparam t_status ST_PAYLEN     = 3'd7;

    localparam t_reg_idx REG_EXP_VERSION = 8'd0;
    localparam t_reg_idx REG_MAX_KIND    = 8'd1;
    localparam t_reg_idx REG_MAX_PAYLOAD = 8'd2;
    localparam t_reg_idx REG_MAX_DEF     = 8'd3;

    localparam logic [15:0] RST_EXP_VERSION = 16'd2;
    localparam logic [7:0]  RST_MAX_KIND    = 8'd7;
    localparam logic [31:0] RST_MAX_PAYLOAD = 32'd16777216;
    localparam logic [31:0] RST_MAX_DEF     = 32'd1048576;

    // "NBZ2"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h4E;
            2'd1:    b = 8'h42;
            2'd2:    b = 8'h5A;
            default: b = 8'h32;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] hdr_len(input t_sec sec);
        logic [3:0] n;
        unique case (sec)
            SEC_VERSION: n = 4'd2;
            SEC_KIND:    n = 4'd1;
            SEC_FLAGS:   n = 4'd1;
            SEC_SEQ:     n = 4'd8;
            SEC_TIME:    n = 4'd8;
            default:     n = 4'd4;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/envelope_frame_parser_unit.sv =====
// ----------------------------------------------------------------------------
// envelope_frame_parser_unit
// byte-serial envelope frame checker with section tagging and frame verdict
// ----------------------------------------------------------------------------
//  channel   dir  request fields
//  s_axis    in   tdata[7:0] byte, tlast frame end
//  m_axis    out  tdata byte/status, tuser section/prefix, tlast frame end
//  cfg       in   i_cfg_index register, i_cfg_data value
//
//  one byte per cycle unless the output stalls; the result is registered in the cycle after acceptance
//  all parse decisions come from the state registers and the current byte
//  reset (synchronous, active low) clears parse state and loads default limits
//  a stalled output register holds off input only while it is full and unread
// ----------------------------------------------------------------------------
`include "envelope_frame_parser_unit_defines.svh"

module envelope_frame_parser_unit
    import efp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status, rest zero
    output logic [5:0]  m_axis_tuser,   // [4:0] section, [5] is_prefix
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  t_reg_idx    i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [15:0] r_exp_ver;
    logic [7:0]  r_max_kind;
    logic [31:0] r_max_pay;
    logic [31:0] r_max_def;

    t_sec        r_sec, n_sec;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    t_status     r_pend, n_pend;
    t_status     r_err, n_err;
    logic        r_drop, n_drop;

    logic        r_ov;
    logic [7:0]  r_obyte, n_obyte;
    t_sec        r_osec, n_osec;
    logic        r_opre, n_opre;
    logic        r_olast;
    t_status     r_ost, n_ost;

    logic        in_acc;
    logic        res;
    logic        emit;
    logic        pre;
    t_status     err;
    t_status     end_st;
    t_status     st;
    t_sec        sec_o;
    t_sec        sec_inc;
    logic [3:0]  cnt_inc;
    logic [3:0]  pw;
    logic [31:0] acc_shift;
    logic [31:0] acc_dec;
    logic [7:0]  b;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_ov || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    assign cnt_inc   = r_cnt + 4'd1;
    assign sec_inc   = r_sec + 5'd1;
    assign acc_shift = {r_acc[23:0], b};
    assign acc_dec   = r_acc - 32'd1;
    assign pw        = (r_sec == SEC_LONG_STR) ? 4'd4 : 4'd2;

    always_comb begin
        n_sec  = r_sec;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_pend = r_pend;
        n_err  = r_err;
        n_drop = r_drop;
        err    = ST_OK;
        emit   = 1'b0;
        pre    = 1'b0;
        sec_o  = r_sec;
        if (!r_drop) begin
            if (r_sec == SEC_MAGIC) begin
                if (b != magic_byte(r_cnt[1:0])) begin
                    err = ST_MAGIC;
                end else if (cnt_inc >= 4'd4) begin
                    n_sec = SEC_VERSION;
                    n_cnt = 4'd0;
                    n_acc = 32'd0;
                end else begin
                    n_cnt = cnt_inc;
                end
            end else if (r_sec <= SEC_HDRSEQ) begin
                n_acc = acc_shift;
                n_cnt = cnt_inc;
                if (r_sec == SEC_VERSION && cnt_inc == 4'd2 &&
                    acc_shift[15:0] != r_exp_ver && r_pend == ST_OK) begin
                    n_pend = ST_VERSION;
                end
                if (r_sec == SEC_KIND && b > r_max_kind && r_pend == ST_OK) begin
                    n_pend = ST_KIND;
                end
                if (cnt_inc >= hdr_len(r_sec)) begin
                    if (r_sec == SEC_HDRSEQ && r_pend != ST_OK) begin
                        err = r_pend;
                    end else begin
                        n_sec = sec_inc;
                        n_cnt = 4'd0;
                        n_acc = 32'd0;
                    end
                end
            end else if (r_sec <= SEC_STR_LAST) begin
                if (r_cnt < pw) begin
                    pre   = 1'b1;
                    n_acc = acc_shift;
                    n_cnt = cnt_inc;
                    if (cnt_inc == pw) begin
                        if (r_sec == SEC_LONG_STR && acc_shift > r_max_def) begin
                            err = ST_SHORT_META;
                        end else if (acc_shift == 32'd0) begin
                            n_sec = sec_inc;
                            n_cnt = 4'd0;
                        end
                    end
                end else begin
                    n_acc = acc_dec;
                    if (acc_dec == 32'd0) begin
                        n_sec = sec_inc;
                        n_cnt = 4'd0;
                    end
                end
            end else if (r_sec == SEC_LATCH) begin
                if (b > 8'd1) begin
                    err = ST_LATCH;
                end else begin
                    n_sec = SEC_PAYLEN;
                    n_cnt = 4'd0;
                    n_acc = 32'd0;
                end
            end else if (r_sec == SEC_PAYLEN) begin
                n_acc = acc_shift;
                n_cnt = cnt_inc;
                if (cnt_inc >= 4'd4) begin
                    if (acc_shift > r_max_pay) begin
                        err = ST_PAYLEN;
                    end else begin
                        n_sec = SEC_PAYLOAD;
                        n_cnt = 4'd0;
                    end
                end
            end else begin
                sec_o = SEC_PAYLOAD;
                if (r_acc == 32'd0) begin
                    err = ST_PAYLEN;
                end else begin
                    n_acc = acc_dec;
                end
            end
            if (err != ST_OK) begin
                n_err  = err;
                n_drop = 1'b1;
            end else begin
                emit = 1'b1;
            end
        end

        // verdict for a frame that ends here
        priority if (n_sec == SEC_MAGIC) begin
            end_st = ST_MAGIC;
        end else if (n_sec <= SEC_HDRSEQ) begin
            end_st = ST_SHORT_HDR;
        end else if (n_sec <= SEC_STR_LAST) begin
            end_st = ST_SHORT_META;
        end else if (n_sec == SEC_LATCH) begin
            end_st = ST_LATCH;
        end else if (n_sec == SEC_PAYLEN) begin
            end_st = ST_PAYLEN;
        end else begin
            end_st = (n_acc == 32'd0) ? ST_OK : ST_PAYLEN;
        end
        st = n_drop ? n_err : end_st;

        res     = emit || s_axis_tlast;
        n_obyte = b;
        n_osec  = sec_o;
        n_opre  = pre;
        n_ost   = ST_OK;
        if (s_axis_tlast) begin
            n_ost = st;
            if (!(emit && st == ST_OK)) begin
                n_obyte = 8'd0;
                n_osec  = SEC_MAGIC;
                n_opre  = 1'b0;
            end
            n_sec  = SEC_MAGIC;
            n_cnt  = 4'd0;
            n_acc  = 32'd0;
            n_pend = ST_OK;
            n_err  = ST_OK;
            n_drop = 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver  <= RST_EXP_VERSION;
            r_max_kind <= RST_MAX_KIND;
            r_max_pay  <= RST_MAX_PAYLOAD;
            r_max_def  <= RST_MAX_DEF;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_EXP_VERSION: r_exp_ver  <= i_cfg_data[15:0];
                REG_MAX_KIND:    r_max_kind <= i_cfg_data[7:0];
                REG_MAX_PAYLOAD: r_max_pay  <= i_cfg_data;
                REG_MAX_DEF:     r_max_def  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec  <= SEC_MAGIC;
            r_cnt  <= 4'd0;
            r_acc  <= 32'd0;
            r_pend <= ST_OK;
            r_err  <= ST_OK;
            r_drop <= 1'b0;
        end else if (in_acc) begin
            r_sec  <= n_sec;
            r_cnt  <= n_cnt;
            r_acc  <= n_acc;
            r_pend <= n_pend;
            r_err  <= n_err;
            r_drop <= n_drop;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (in_acc) begin
            r_ov <= res;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res) begin
            r_obyte <= n_obyte;
            r_osec  <= n_osec;
            r_opre  <= n_opre;
            r_olast <= s_axis_tlast;
            r_ost   <= n_ost;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {5'd0, r_ost, r_obyte};
    assign m_axis_tuser  = {r_opre, r_osec};
    assign m_axis_tlast  = r_olast;

    `EFP_ASSERT_NOW(a_err_only_at_end, m_axis_tvalid && r_ost != ST_OK, m_axis_tlast)
    `EFP_ASSERT_NOW(a_err_zero_payload, m_axis_tvalid && r_ost != ST_OK,
        r_obyte == 8'd0 && r_osec == SEC_MAGIC && !r_opre)
    `EFP_ASSERT_NEXT(a_frame_clear, in_acc && s_axis_tlast,
        r_sec == SEC_MAGIC && !r_drop && r_pend == ST_OK)
    `EFP_ASSERT_NOW(a_drop_has_code, r_drop, r_err != ST_OK)

endmodule
